// ===== src/ilb_pkg.sv =====
`default_nettype none

package ilb_pkg;

  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 7;
  localparam int IN_TD_W  = 48;
  localparam int OUT_TD_W = 48;
  localparam int GRP_SIZE = 8;
  localparam int READ_SPAN = 64;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_EDIT   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic wr;
    logic ins;
    logic del;
    logic rd;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/ilb_cell.sv =====
`default_nettype none

module ilb_cell import ilb_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IW    = 6,
  parameter int VW    = 32
) (
  input  wire logic          clk,
  input  wire cell_ctrl_t    ctrl,
  input  wire logic [IW-1:0] tgt,
  input  wire logic [VW-1:0] wr_data,
  input  wire logic [VW-1:0] left_data,
  input  wire logic [VW-1:0] right_data,
  output logic      [VW-1:0] data_o,
  output logic      [VW-1:0] rd_o
);

  logic [VW-1:0] data_r;
  logic [VW-1:0] data_nxt;
  logic          hit;
  logic          above;

  assign hit   = (IW'(INDEX) == tgt);
  assign above = (IW'(INDEX) > tgt);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (hit) begin
        data_nxt = wr_data;
      end else if (above) begin
        data_nxt = left_data;
      end
    end else if (ctrl.del) begin
      if (hit || above) begin
        data_nxt = right_data;
      end
    end else if (ctrl.wr && hit) begin
      data_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (ctrl.rd && hit) ? data_r : '0;

endmodule

`default_nettype wire

// ===== src/indexed_list_buffer_core.sv =====
`default_nettype none

// Indexed list buffer: an ordered list of signed values, CAPACITY entries.
// Input channel in_*: one command per item (append, read, edit, insert
// before index, delete). Result channel out_*: exactly one result per
// command with status, read value and the list length after the command.
// Storage is a row of cells, one element each; insert and delete move
// every later element to its neighbor cell at once.
// On acceptance the cell update and the first level of the read OR tree
// are registered into the middle stage; the final OR level is registered
// into the output register. Throughput: one command per cycle while
// the receiver takes results; the read tree and cell row set this rate.
// Reset (rst_n low, synchronous) empties the list; element contents are
// undefined until written and are never visible.
// When the receiver stalls, the finished result is held in the output
// register and one more command is taken into the middle stage; after
// that in_tready drops until out_tready returns.

module indexed_list_buffer_core import ilb_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [IN_TD_W-1:0]  in_tdata,   // op[2:0], position[8:3], value[40:9]
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_TD_W-1:0]      out_tdata   // status[1:0], read_value[33:2], length[40:34]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int VW = VALUE_WIDTH;
  localparam int RN = (CAPACITY < READ_SPAN) ? CAPACITY : READ_SPAN;
  localparam int NG = (RN + GRP_SIZE - 1) / GRP_SIZE;

  logic [2:0]        in_op;
  logic [POS_W-1:0]  in_position;
  logic [DATA_W-1:0] in_value;
  logic [VW-1:0]     store_val;

  logic              in_fire;
  logic              a_move;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  status_t           status;
  cell_ctrl_t        ctrl;
  logic [IW-1:0]     tgt;
  logic              in_range;
  logic              full;

  logic [VW-1:0]     cell_q  [CAPACITY];
  logic [VW-1:0]     cell_rd [CAPACITY];
  logic [VW-1:0]     grp_nxt [NG];

  logic              a_valid_r;
  logic              a_valid_nxt;
  status_t           a_status_r;
  logic [LEN_W-1:0]  a_len_r;
  logic [VW-1:0]     a_grp_r [NG];

  logic              out_valid_r;
  logic              out_valid_nxt;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [VW-1:0]     rd_or;
  logic [DATA_W-1:0] rd_ext;

  assign in_op       = in_tdata[2:0];
  assign in_position = in_tdata[8:3];
  assign in_value    = in_tdata[40:9];

  generate
    if (VW <= DATA_W) begin : g_st_narrow
      assign store_val = in_value[VW-1:0];
    end else begin : g_st_wide
      assign store_val = {{(VW-DATA_W){in_value[DATA_W-1]}}, in_value};
    end
  endgenerate

  assign a_move    = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_move;
  assign in_fire   = in_tvalid && in_tready;

  assign in_range = (XW'(in_position) < XW'(count_r));
  assign full     = (count_r == CW'(CAPACITY));

  always_comb begin
    status    = ST_OK;
    ctrl      = '0;
    tgt       = IW'(in_position);
    count_nxt = count_r;
    case (op_t'(in_op))
      OP_APPEND: begin
        tgt = IW'(count_r);
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.wr   = in_fire;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_READ: begin
        if (in_range) begin
          ctrl.rd = in_fire;
        end else begin
          status = ST_RANGE;
        end
      end
      OP_EDIT: begin
        if (in_range) begin
          ctrl.wr = in_fire;
        end else begin
          status = ST_RANGE;
        end
      end
      OP_INSERT: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins  = in_fire;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          ctrl.del  = in_fire;
          count_nxt = count_r - CW'(1);
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VW-1:0] left_d;
      logic [VW-1:0] right_d;
      if (gi == 0) begin : g_lft_end
        assign left_d = store_val;
      end else begin : g_lft
        assign left_d = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_rgt_end
        assign right_d = store_val;
      end else begin : g_rgt
        assign right_d = cell_q[gi+1];
      end
      ilb_cell #(
        .INDEX (gi),
        .IW    (IW),
        .VW    (VW)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .tgt        (tgt),
        .wr_data    (store_val),
        .left_data  (left_d),
        .right_data (right_d),
        .data_o     (cell_q[gi]),
        .rd_o       (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < RN) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g*GRP_SIZE+k];
        end
      end
    end
  end

  always_comb begin
    rd_or = '0;
    for (int g = 0; g < NG; g++) begin
      rd_or = rd_or | a_grp_r[g];
    end
  end

  generate
    if (VW >= DATA_W) begin : g_rd_wide
      assign rd_ext = rd_or[DATA_W-1:0];
    end else begin : g_rd_narrow
      assign rd_ext = {{(DATA_W-VW){rd_or[VW-1]}}, rd_or};
    end
  endgenerate

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (a_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_status_r <= status;
      a_len_r    <= LEN_W'(count_nxt);
      for (int g = 0; g < NG; g++) begin
        a_grp_r[g] <= grp_nxt[g];
      end
    end
    if (a_move) begin
      out_status_r <= a_status_r;
      out_rd_r     <= rd_ext;
      out_len_r    <= a_len_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TD_W-LEN_W-DATA_W-2){1'b0}}, out_len_r, out_rd_r, out_status_r};

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count exceeds capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_rd_r == '0))
    else $error("failed command returned nonzero read value");

  a_fire_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> a_valid_r)
    else $error("accepted item lost before middle stage");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && out_valid_r && !out_tready |=> a_valid_r && $stable(a_len_r))
    else $error("middle stage dropped while output stalled");
`endif

endmodule

`default_nettype wire
